FILE: rtl/pel_pkg.sv
package pel_pkg;

	localparam int COORD_W = 19;
	localparam int MAG_W   = 19;
	localparam int SQ_W    = 38;
	localparam int DIST_W  = 38;
	localparam int CNT_W   = 16;
	localparam int CFG_W   = 38;
	localparam int CFG_IDX_W = 2;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic [MAG_W-1:0]          mag_t;
	typedef logic [SQ_W-1:0]           sq_t;
	typedef logic [DIST_W-1:0]         dist_t;
	typedef logic [CNT_W-1:0]          cnt_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_COLLISION_DIST = 2'd0,
		CFG_NEAR_MISS_DIST = 2'd1,
		CFG_SWEEP_MIN      = 2'd2
	} cfg_idx_t;

	localparam cnt_t  CNT_MAX            = '1;
	localparam dist_t COLLISION_DIST_RST = DIST_W'(1000000);
	localparam dist_t NEAR_MISS_DIST_RST = DIST_W'(4000000);
	localparam dist_t SWEEP_MIN_RST      = '1;

endpackage

FILE: rtl/pel_dist_sq.sv
module pel_dist_sq (
	input  logic           clk,
	input  logic           en,
	input  pel_pkg::coord_t rel_x,
	input  pel_pkg::coord_t rel_y,
	input  pel_pkg::coord_t rel_z,
	output pel_pkg::dist_t  sq_sum
);
	import pel_pkg::*;

	mag_t  mag_x, mag_y, mag_z;
	sq_t   sq_x_s2, sq_y_s2, sq_z_s2;
	dist_t dist_s3;

	// take magnitude; the most negative value maps to 2^18
	assign mag_x = rel_x[COORD_W-1] ? MAG_W'(-rel_x) : MAG_W'(rel_x);
	assign mag_y = rel_y[COORD_W-1] ? MAG_W'(-rel_y) : MAG_W'(rel_y);
	assign mag_z = rel_z[COORD_W-1] ? MAG_W'(-rel_z) : MAG_W'(rel_z);

	always_ff @(posedge clk) begin
		if (en) begin
			sq_x_s2 <= SQ_W'(mag_x * mag_x);
			sq_y_s2 <= SQ_W'(mag_y * mag_y);
			sq_z_s2 <= SQ_W'(mag_z * mag_z);
			dist_s3 <= DIST_W'(sq_x_s2 + sq_y_s2 + sq_z_s2);
		end
	end

	assign sq_sum = dist_s3;

endmodule

FILE: rtl/proximity_event_logger.sv
// Proximity event logger. Takes one word per cycle carrying a neighbour slot and its relative
// position in millimetres, and returns one word per input word: the squared distance, the
// saturating collision and near-miss totals, the events raised by this word, and the running
// minimum and maximum squared distance of the current sweep. Throughput is one word per clock
// unless out_stall holds the result word. The pipeline runs through the input register, the
// three 19x19 squaring multipliers, the three-way sum and the result register. Per-slot
// collided, near-miss and transition marks live in flip-flops (NEIGHBOR_SLOTS of each); the
// slot field is taken modulo NEIGHBOR_SLOTS. The user must write the thresholds and the sweep
// minimum start value (cfg_we/cfg_index/cfg_data) with no word in flight; nothing checks it.
module proximity_event_logger #(
	parameter int NEIGHBOR_SLOTS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,

	input  logic                        cfg_we,
	input  logic [pel_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [pel_pkg::CFG_W-1:0]   cfg_data,

	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [3:0]                  slot,
	input  pel_pkg::coord_t             rel_x,
	input  pel_pkg::coord_t             rel_y,
	input  pel_pkg::coord_t             rel_z,
	input  logic                        sweep_start,
	input  logic                        armed,

	output logic                        out_valid,
	input  logic                        out_stall,
	output pel_pkg::dist_t              dist_sqr,
	output pel_pkg::cnt_t               collision_total,
	output pel_pkg::cnt_t               near_miss_total,
	output logic                        new_collision,
	output logic                        new_near_miss,
	output pel_pkg::dist_t              min_dist_sqr,
	output pel_pkg::dist_t              max_dist_sqr
);
	import pel_pkg::*;

	localparam int IDX_W = (NEIGHBOR_SLOTS > 1) ? $clog2(NEIGHBOR_SLOTS) : 1;

	typedef logic [IDX_W-1:0] idx_t;

	typedef struct packed {
		idx_t idx;
		logic sweep;
		logic armed;
	} ctl_t;

	function automatic idx_t wrap_slot(logic [3:0] s);
		idx_t w;
		w = '0;
		for (int i = 0; i < 16; i++) begin
			if (s == 4'(i)) w = IDX_W'(i % NEIGHBOR_SLOTS);
		end
		return w;
	endfunction

	dist_t coll_thr_q, nm_thr_q, sweep_min_q;

	logic en;
	logic v_s1, v_s2, v_s3, out_valid_q;
	ctl_t ctl_s1, ctl_s2, ctl_s3;
	coord_t rel_x_s1, rel_y_s1, rel_z_s1;
	dist_t dist_s3;

	logic [NEIGHBOR_SLOTS-1:0] col_mark_q, nm_mark_q, tr_mark_q;
	logic [NEIGHBOR_SLOTS-1:0] col_mark_d, nm_mark_d, tr_mark_d;
	cnt_t  coll_cnt_q, nm_cnt_q, coll_cnt_d, nm_cnt_d;
	dist_t run_min_q, run_max_q, run_min_d, run_max_d;
	logic  newc_d, newn_d;

	dist_t dist_sqr_q, min_q, max_q;
	logic  newc_q, newn_q;

	// advance the whole pipeline unless the result word is held
	assign en       = !(out_valid_q && out_stall);
	assign in_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coll_thr_q  <= COLLISION_DIST_RST;
			nm_thr_q    <= NEAR_MISS_DIST_RST;
			sweep_min_q <= SWEEP_MIN_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_COLLISION_DIST: coll_thr_q  <= DIST_W'(cfg_data);
				CFG_NEAR_MISS_DIST: nm_thr_q    <= DIST_W'(cfg_data);
				CFG_SWEEP_MIN:      sweep_min_q <= DIST_W'(cfg_data);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s1        <= in_valid;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			out_valid_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s1.idx   <= wrap_slot(slot);
			ctl_s1.sweep <= sweep_start;
			ctl_s1.armed <= armed;
			rel_x_s1     <= rel_x;
			rel_y_s1     <= rel_y;
			rel_z_s1     <= rel_z;
			ctl_s2       <= ctl_s1;
			ctl_s3       <= ctl_s2;
		end
	end

	pel_dist_sq u_dist_sq (
		.clk    (clk),
		.en     (en),
		.rel_x  (rel_x_s1),
		.rel_y  (rel_y_s1),
		.rel_z  (rel_z_s1),
		.sq_sum (dist_s3)
	);

	always_comb begin
		dist_t base_min, base_max;
		logic  lt_c, lt_n, gt_c, gt_n;

		base_min = ctl_s3.sweep ? sweep_min_q : run_min_q;
		base_max = ctl_s3.sweep ? '0 : run_max_q;
		lt_c = dist_s3 < coll_thr_q;
		lt_n = dist_s3 < nm_thr_q;
		gt_c = dist_s3 > coll_thr_q;
		gt_n = dist_s3 > nm_thr_q;

		col_mark_d = col_mark_q;
		nm_mark_d  = nm_mark_q;
		tr_mark_d  = tr_mark_q;
		coll_cnt_d = coll_cnt_q;
		nm_cnt_d   = nm_cnt_q;
		run_min_d  = base_min;
		run_max_d  = base_max;
		newc_d     = 1'b0;
		newn_d     = 1'b0;

		if (ctl_s3.armed) begin
			if (dist_s3 < base_min) run_min_d = dist_s3;
			if (dist_s3 > base_max) run_max_d = dist_s3;

			if (lt_c && !col_mark_q[ctl_s3.idx]) begin
				if (coll_cnt_q != CNT_MAX) coll_cnt_d = CNT_W'(coll_cnt_q + 1'b1);
				newc_d = 1'b1;
				if (nm_cnt_q != '0 && !tr_mark_q[ctl_s3.idx]) begin
					nm_cnt_d = CNT_W'(nm_cnt_q - 1'b1);
					tr_mark_d[ctl_s3.idx] = 1'b1;
				end
				col_mark_d[ctl_s3.idx] = 1'b1;
			end else if (lt_n && !nm_mark_q[ctl_s3.idx]) begin
				if (nm_cnt_q != CNT_MAX) nm_cnt_d = CNT_W'(nm_cnt_q + 1'b1);
				newn_d = 1'b1;
				nm_mark_d[ctl_s3.idx] = 1'b1;
			end else if (gt_n) begin
				col_mark_d[ctl_s3.idx] = 1'b0;
				nm_mark_d[ctl_s3.idx]  = 1'b0;
				tr_mark_d[ctl_s3.idx]  = 1'b0;
			end else if (gt_c) begin
				col_mark_d[ctl_s3.idx] = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_mark_q <= '0;
			nm_mark_q  <= '0;
			tr_mark_q  <= '0;
			coll_cnt_q <= '0;
			nm_cnt_q   <= '0;
			run_min_q  <= '1;
			run_max_q  <= '0;
		end else if (en && v_s3) begin
			col_mark_q <= col_mark_d;
			nm_mark_q  <= nm_mark_d;
			tr_mark_q  <= tr_mark_d;
			coll_cnt_q <= coll_cnt_d;
			nm_cnt_q   <= nm_cnt_d;
			run_min_q  <= run_min_d;
			run_max_q  <= run_max_d;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dist_sqr_q <= dist_s3;
			newc_q     <= newc_d;
			newn_q     <= newn_d;
			min_q      <= run_min_d;
			max_q      <= run_max_d;
		end
	end

	assign out_valid       = out_valid_q;
	assign dist_sqr        = dist_sqr_q;
	assign collision_total = coll_cnt_q;
	assign near_miss_total = nm_cnt_q;
	assign new_collision   = newc_q;
	assign new_near_miss   = newn_q;
	assign min_dist_sqr    = min_q;
	assign max_dist_sqr    = max_q;

	a_coll_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		coll_cnt_q >= $past(coll_cnt_q))
		else $error("collision count went down");

	a_nm_step: assert property (@(posedge clk) disable iff (!arst_n)
		nm_cnt_q == $past(nm_cnt_q) ||
		nm_cnt_q == CNT_W'($past(nm_cnt_q) + 1'b1) ||
		nm_cnt_q == CNT_W'($past(nm_cnt_q) - 1'b1))
		else $error("near-miss count moved by more than one");

	a_newc_counted: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && newc_q |-> coll_cnt_q != '0)
		else $error("collision flagged with zero total");

	a_new_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		en && v_s3 |-> !(newc_d && newn_d))
		else $error("collision and near miss raised by one word");

endmodule
